[rtl/core/kmsd_pkg.sv]
// Shared types, constants and key table for the keypad matrix scanner.
package kmsd_pkg;

    localparam int ROWS_W        = 4;
    localparam int COLS_W        = 4;
    localparam int MAP_W         = 16;
    localparam int KEY_IDX_W     = $clog2(MAP_W);
    localparam int CODE_W        = 7;
    localparam int SETTLE_W      = 16;
    localparam int PERIOD_W      = 20;
    localparam int HISTORY_DEPTH = 10;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;

    // Register indexes, taken from address bit 2 (word-aligned registers).
    localparam logic REG_SETTLE = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(100);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20000);

    // Scan phases: idle, then one phase per driven column, col4 first.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_COL4 = 3'd1,
        PH_COL3 = 3'd2,
        PH_COL2 = 3'd3,
        PH_COL1 = 3'd4
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } key_report_t;

    // Character of each key, indexed by its bit number in the pressed map.
    function automatic logic [CODE_W-1:0] key_char(input logic [KEY_IDX_W-1:0] idx);
        logic [CODE_W-1:0] c;
        case (idx)
            4'd0:    c = 7'h44;  // D
            4'd1:    c = 7'h43;  // C
            4'd2:    c = 7'h42;  // B
            4'd3:    c = 7'h41;  // A
            4'd4:    c = 7'h2A;  // *
            4'd5:    c = 7'h39;  // 9
            4'd6:    c = 7'h36;  // 6
            4'd7:    c = 7'h33;  // 3
            4'd8:    c = 7'h30;  // 0
            4'd9:    c = 7'h38;  // 8
            4'd10:   c = 7'h35;  // 5
            4'd11:   c = 7'h32;  // 2
            4'd12:   c = 7'h23;  // #
            4'd13:   c = 7'h37;  // 7
            4'd14:   c = 7'h34;  // 4
            default: c = 7'h31;  // 1
        endcase
        return c;
    endfunction

    // Column levels for a phase: the driven column is low, the rest high.
    function automatic logic [COLS_W-1:0] col_drive_for(input phase_t ph);
        logic [COLS_W-1:0] d;
        case (ph)
            PH_COL4: d = 4'h7;
            PH_COL3: d = 4'hB;
            PH_COL2: d = 4'hD;
            PH_COL1: d = 4'hE;
            default: d = 4'h0;
        endcase
        return d;
    endfunction

endpackage

[rtl/core/keypad_matrix_scan_debounce.sv]
// Top level of the 4x4 keypad matrix scanner with debounce and APB configuration.
// A request is held in the input register until the result register can take it; logic
// then writes the result register. Scan counters and history ring update in one pass.
// Throughput: one request per cycle while the result channel is not stalled.
// Reset (rst_n, asynchronous, active low) clears all scan state and the history ring,
// loads settle 100 and period 20000; the first request starts a scan if any row is low.
module keypad_matrix_scan_debounce (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input channel: one request per clock tick of the keypad.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [kmsd_pkg::ROWS_W-1:0]        row_pins,
    // Result channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [kmsd_pkg::COLS_W-1:0]        col_drive,
    output logic                               key_valid,
    output logic [kmsd_pkg::CODE_W-1:0]        key_code,
    output logic [kmsd_pkg::MAP_W-1:0]         stable_map,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kmsd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [kmsd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [kmsd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import kmsd_pkg::*;

    // Configuration registers.
    logic [SETTLE_W-1:0] settle_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                cfg_write;

    // Input register and pipeline control.
    logic                in_valid_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic                advance;

    // Scan state.
    logic [PERIOD_W-1:0] period_count_reg;
    logic [PERIOD_W-1:0] period_count_next;
    logic [SETTLE_W-1:0] settle_count_reg;
    logic [SETTLE_W-1:0] settle_count_next;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [MAP_W-1:0]    partial_reg;
    logic [MAP_W-1:0]    partial_next;

    logic [SETTLE_W-1:0] settle_eff;
    logic [PERIOD_W-1:0] period_eff;
    logic                scan_start;
    logic [SETTLE_W:0]   settle_inc;
    logic [PERIOD_W:0]   period_inc;
    logic                commit_c;
    logic [MAP_W-1:0]    commit_map;
    logic [MAP_W-1:0]    rows_shifted;

    // Debounce results for this pass.
    logic [MAP_W-1:0]    stable_next;
    key_report_t         report;

    // Result register.
    logic                out_valid_reg;
    logic [COLS_W-1:0]   col_drive_reg;
    logic                key_valid_reg;
    logic [CODE_W-1:0]   key_code_reg;
    logic [MAP_W-1:0]    stable_map_reg;

    //------------------------------------------------------------------
    // Configuration. Registers are word aligned, so address bit 2 picks
    // the register and the byte-offset bits are ignored.
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_SETTLE: settle_reg <= pwdata[SETTLE_W-1:0];
                REG_PERIOD: period_reg <= pwdata[PERIOD_W-1:0];
                default:    settle_reg <= settle_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SETTLE: prdata = CFG_DATA_W'(settle_reg);
            REG_PERIOD: prdata = CFG_DATA_W'(period_reg);
            default:    prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Handshake. A request waits in the input register until the result
    // register is free or is being taken in the same cycle, so a held
    // request stalls the input while an older result is still stalled.
    //------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            rows_reg <= row_pins;
        end
    end

    //------------------------------------------------------------------
    // Scan sequencer. A register value of zero behaves as one tick.
    // A period that ends while a scan is still running is skipped.
    //------------------------------------------------------------------
    assign settle_eff = (settle_reg == '0) ? SETTLE_W'(1) : settle_reg;
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign scan_start = (period_count_reg == '0);
    assign settle_inc = {1'b0, settle_count_reg} + (SETTLE_W + 1)'(1);
    assign period_inc = {1'b0, period_count_reg} + (PERIOD_W + 1)'(1);

    assign period_count_next = (period_inc >= {1'b0, period_eff}) ? '0
                                                                  : period_inc[PERIOD_W-1:0];

    // The rows sampled while column N is driven land in nibble N-1 of the map.
    always_comb
    begin
        case (phase_reg)
            PH_COL4: rows_shifted = MAP_W'(rows_reg) << 12;
            PH_COL3: rows_shifted = MAP_W'(rows_reg) << 8;
            PH_COL2: rows_shifted = MAP_W'(rows_reg) << 4;
            default: rows_shifted = MAP_W'(rows_reg);
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        settle_count_next = settle_count_reg;
        partial_next      = partial_reg;
        commit_c          = 1'b0;
        commit_map        = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (scan_start)
                begin
                    if (rows_reg != '1)
                    begin
                        phase_next        = PH_COL4;
                        settle_count_next = '0;
                        partial_next      = '0;
                    end
                    else
                    begin
                        // No row is low: this scan's map is empty.
                        commit_c = 1'b1;
                    end
                end
            end
            PH_COL4, PH_COL3, PH_COL2, PH_COL1:
            begin
                if (settle_inc >= {1'b0, settle_eff})
                begin
                    partial_next      = partial_reg | rows_shifted;
                    settle_count_next = '0;
                    case (phase_reg)
                        PH_COL4: phase_next = PH_COL3;
                        PH_COL3: phase_next = PH_COL2;
                        PH_COL2: phase_next = PH_COL1;
                        default:
                        begin
                            phase_next = PH_IDLE;
                            commit_c   = 1'b1;
                            commit_map = ~(partial_reg | rows_shifted);
                        end
                    endcase
                end
                else
                begin
                    settle_count_next = settle_inc[SETTLE_W-1:0];
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= '0;
            settle_count_reg <= '0;
            phase_reg        <= PH_IDLE;
            partial_reg      <= '0;
        end
        else if (advance)
        begin
            period_count_reg <= period_count_next;
            settle_count_reg <= settle_count_next;
            phase_reg        <= phase_next;
            partial_reg      <= partial_next;
        end
    end

    //------------------------------------------------------------------
    // History ring and key detection.
    //------------------------------------------------------------------
    kmsd_debounce u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (advance && commit_c),
        .scan_map    (commit_map),
        .stable_next (stable_next),
        .report      (report)
    );

    //------------------------------------------------------------------
    // Result register.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col_drive_reg  <= col_drive_for(phase_next);
            key_valid_reg  <= report.valid;
            key_code_reg   <= report.code;
            stable_map_reg <= stable_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign col_drive  = col_drive_reg;
    assign key_valid  = key_valid_reg;
    assign key_code   = key_code_reg;
    assign stable_map = stable_map_reg;

    //------------------------------------------------------------------
    // Assertions.
    //------------------------------------------------------------------
    // A reported key is always the only key in the debounced map.
    a_key_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_valid) |-> $onehot(stable_map))
        else $error("key reported while the debounced map is not a single key");

    // Columns are either all low or exactly one of them is driven low.
    a_col_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((col_drive == '0) || ($countones(col_drive) == 3)))
        else $error("column drive pattern is not idle or a single low column");

    // A reported key always carries a nonzero character code.
    a_key_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_valid) |-> (key_code != '0))
        else $error("key reported with an empty character code");

    // The sequencer never rests in a phase while the columns show idle.
    a_phase_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (phase_next != PH_IDLE)) |=> (col_drive != '0))
        else $error("scan phase active but result shows idle column drive");

endmodule

[rtl/core/kmsd_debounce.sv]
// Scan history ring, debounced map and single-key report for the keypad scanner.
module kmsd_debounce (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        commit,
    input  logic [kmsd_pkg::MAP_W-1:0]  scan_map,
    output logic [kmsd_pkg::MAP_W-1:0]  stable_next,
    output kmsd_pkg::key_report_t       report
);
    import kmsd_pkg::*;

    logic [MAP_W-1:0]     hist_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [MAP_W-1:0]     deb_reg;
    logic [MAP_W-1:0]     acc;
    logic                 changed;
    logic                 one_hot;
    logic [KEY_IDX_W-1:0] key_idx;

    // The AND includes the map being written this cycle in place of the old slot.
    always_comb
    begin
        acc = '1;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            acc = acc & ((slot_reg == SLOT_W'(i)) ? scan_map : hist_reg[i]);
        end
    end

    always_comb
    begin
        key_idx = '0;
        for (int i = 0; i < MAP_W; i++)
        begin
            key_idx = key_idx | (acc[i] ? KEY_IDX_W'(i) : '0);
        end
    end

    assign changed     = commit && (acc != deb_reg);
    assign one_hot     = (acc != '0) && ((acc & (acc - MAP_W'(1))) == '0);
    assign stable_next = changed ? acc : deb_reg;
    assign report.valid = changed && one_hot;
    assign report.code  = (changed && one_hot) ? key_char(key_idx) : '0;
    assign slot_next    = (slot_reg >= SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                   : slot_reg + SLOT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            slot_reg <= '0;
            deb_reg  <= '0;
        end
        else if (commit)
        begin
            hist_reg[slot_reg] <= scan_map;
            slot_reg           <= slot_next;
            deb_reg            <= stable_next;
        end
    end

endmodule
